// ===== design/uist_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uist_pkg
// Shared types and constants of the unique item set table.
// ----------------------------------------------------------------------------
package uist_pkg;

  localparam int unsigned CapacityDef   = 16;
  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned FuncWidth     = 2;
  localparam int unsigned ItemWidth     = 32;
  localparam int unsigned CountWidth    = 5;

  typedef enum logic [FuncWidth-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } uist_op_e;

  typedef struct packed {
    uist_op_e              func;
    logic [ItemWidth-1:0]  item_value;
  } uist_in_t;

  typedef struct packed {
    logic                  success;
    logic [CountWidth-1:0] entry_count;
  } uist_out_t;

  typedef struct packed {
    logic add_en;
    logic remove_en;
  } uist_ctl_t;

endpackage

// ===== design/unique_item_set_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_item_set_table
// Fixed-capacity set of distinct values built as a row of compare cells.
// ----------------------------------------------------------------------------
// The result is registered and presented in the cycle after its input is taken.
// Throughput: one item per cycle unless the output stalls; all cells compare in
// parallel; a removal closes the gap by moving cells above the hit down by one.
// Reset clears the entry count and the output valid flag; entry contents are
// not cleared, since only cells below the count are ever compared.
module unique_item_set_table
  import uist_pkg::*;
#(
  parameter int unsigned CAPACITY    = CapacityDef,
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  uist_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output uist_out_t out_item_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                   accept;
  logic [VALUE_WIDTH-1:0] value;
  logic [CW-1:0]          count_q, count_d;
  logic                   out_valid_q;
  uist_out_t              out_item_q, out_item_d;
  uist_ctl_t              ctl;
  logic                   found;
  logic                   ok;

  logic [VALUE_WIDTH-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]    hit_w;
  logic [CAPACITY:0]      chain_w;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign value       = VALUE_WIDTH'(in_item_i.item_value);
  assign found       = |hit_w;
  assign chain_w[0]  = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] next_entry;
    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = entry_w[i];
    end else begin : g_mid
      assign next_entry = entry_w[i+1];
    end
    uist_cell #(
      .CAPACITY   (CAPACITY),
      .VALUE_WIDTH(VALUE_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .value_i     (value),
      .count_i     (count_q),
      .hit_chain_i (chain_w[i]),
      .next_entry_i(next_entry),
      .entry_o     (entry_w[i]),
      .hit_o       (hit_w[i]),
      .hit_chain_o (chain_w[i+1])
    );
  end

  always_comb begin
    ctl     = '0;
    count_d = count_q;
    ok      = 1'b0;
    case (in_item_i.func)
      OP_ADD: begin
        ok         = !found && (count_q < CW'(CAPACITY));
        ctl.add_en = accept && ok;
        if (ctl.add_en) begin
          count_d = count_q + CW'(1);
        end
      end
      OP_REMOVE: begin
        ok            = found;
        ctl.remove_en = accept && ok;
        if (ctl.remove_en) begin
          count_d = count_q - CW'(1);
        end
      end
      OP_QUERY: begin
        ok = found;
      end
      default: begin
        ok = 1'b1;
        if (accept) begin
          count_d = '0;
        end
      end
    endcase
  end

  always_comb begin
    out_item_d             = out_item_q;
    out_item_d.success     = ok;
    out_item_d.entry_count = CountWidth'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== design/uist_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uist_cell
// One slot of the set: holds an entry, loads it on add, compares it and shifts on removal.
// ----------------------------------------------------------------------------
module uist_cell
  import uist_pkg::*;
#(
  parameter int unsigned CAPACITY    = CapacityDef,
  parameter int unsigned VALUE_WIDTH = ValueWidthDef,
  parameter int unsigned IDX         = 0,
  localparam int unsigned CW         = $clog2(CAPACITY + 1)
) (
  input  logic                   clk_i,
  input  uist_ctl_t              ctl_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [CW-1:0]          count_i,
  input  logic                   hit_chain_i,
  input  logic [VALUE_WIDTH-1:0] next_entry_i,
  output logic [VALUE_WIDTH-1:0] entry_o,
  output logic                   hit_o,
  output logic                   hit_chain_o
);

  logic [VALUE_WIDTH-1:0] entry_q, entry_d;
  logic                   occupied;

  assign occupied    = count_i > CW'(IDX);
  assign hit_o       = occupied && (entry_q == value_i);
  assign hit_chain_o = hit_chain_i | hit_o;
  assign entry_o     = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.add_en && (count_i == CW'(IDX))) begin
      entry_d = value_i;
    end else if (ctl_i.remove_en && hit_chain_o) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
